// ===== rtl/did_pkg.sv =====
// ----------------------------------------------------------------------------
// did_pkg: shared types and constants for the directional input debouncer
// Register indexes, debounce mode codes and the timer width.
// ----------------------------------------------------------------------------
`default_nettype none

package did_pkg;

    // width of the wrapping timestamp arithmetic (16..64)
    localparam int TIME_BITS = 32;

    localparam int CFG_IDX_BITS = 2;
    localparam int HOLD_BITS    = 16;
    localparam int NOW_BITS     = 32;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_INVERT = 2'd0,
        CFG_ENABLE = 2'd1,
        CFG_MODE   = 2'd2,
        CFG_HOLD   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_FALL  = 2'd0,
        MODE_RISE  = 2'd1,
        MODE_BOTH  = 2'd2,
        MODE_NEVER = 2'd3
    } dbnc_mode_t;

endpackage

`default_nettype wire

// ===== rtl/directional_input_debouncer_unit.sv =====
// ----------------------------------------------------------------------------
// directional_input_debouncer_unit
// Debounces one sampled digital input against a free-running ms timestamp.
// ----------------------------------------------------------------------------
// Pipeline: input register, then the state update, then the result register.
// Throughput: one item per cycle unless out_ready stalls the result register;
//   the state update is a single pass of a compare and one TIME_BITS-wide
//   subtraction between the two registers.
// Configuration writes are taken every cycle (cfg_ready is always high).
// Reset (rst_n low, async): level unknown, nothing pending, mode = both,
//   inversion and debounce off, hold time 0, both pipeline stages empty.
`default_nettype none

module directional_input_debouncer_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          raw_sample,
    input  wire logic [did_pkg::NOW_BITS-1:0]  now_ms,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               changed,
    output logic                               level,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [did_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [did_pkg::HOLD_BITS-1:0] cfg_data
);

    // configuration
    logic                         invert_reg;
    logic                         enable_reg;
    did_pkg::dbnc_mode_t          mode_reg;
    logic [did_pkg::HOLD_BITS-1:0] hold_ms_reg;

    // debounce state
    logic                         level_reg, level_next;
    logic                         known_reg, known_next;
    logic                         pending_reg, pending_next;
    logic                         plevel_reg, plevel_next;
    did_pkg::time_t               start_reg, start_next;

    // input stage
    logic                         in_vld_reg;
    logic                         sample_reg;
    did_pkg::time_t               now_reg;

    // result stage
    logic                         out_vld_reg, out_vld_next;
    logic                         changed_reg;
    logic                         out_level_reg;

    logic                         move;
    logic                         v;
    logic                         differs;
    logic                         active;
    logic                         qualify;
    logic                         bypass;
    logic                         newly;
    logic                         p1;
    logic                         fire;
    logic                         chg;
    did_pkg::time_t               start_eff;
    did_pkg::time_t               elapsed;
    logic                         plevel_eff;

    assign cfg_ready = 1'b1;
    assign move      = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || move;
    assign out_valid = out_vld_reg;
    assign changed   = changed_reg;
    assign level     = out_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg  <= 1'b0;
            enable_reg  <= 1'b0;
            mode_reg    <= did_pkg::MODE_BOTH;
            hold_ms_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (did_pkg::cfg_idx_t'(cfg_index))
                did_pkg::CFG_INVERT: invert_reg  <= cfg_data[0];
                did_pkg::CFG_ENABLE: enable_reg  <= cfg_data[0];
                did_pkg::CFG_MODE:   mode_reg    <= did_pkg::dbnc_mode_t'(cfg_data[1:0]);
                did_pkg::CFG_HOLD:   hold_ms_reg <= cfg_data;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg <= raw_sample;
            now_reg    <= did_pkg::TIME_BITS'(now_ms);
        end
    end

    // single-pass debounce step
    always_comb
    begin
        v       = sample_reg ^ invert_reg;
        differs = !known_reg || (v != level_reg);
        active  = pending_reg || differs;

        qualify = 1'b0;
        bypass  = 1'b0;
        if (!pending_reg && active)
        begin
            unique case (mode_reg)
                did_pkg::MODE_FALL:
                begin
                    qualify = !v;
                    bypass  = v;
                end
                did_pkg::MODE_RISE:
                begin
                    qualify = v;
                    bypass  = !v;
                end
                did_pkg::MODE_BOTH:  qualify = 1'b1;
                did_pkg::MODE_NEVER: qualify = 1'b0;
            endcase
        end

        newly      = qualify;
        start_eff  = newly ? now_reg : start_reg;
        plevel_eff = newly ? v : plevel_reg;
        // flapping back to the old level cancels the pending change
        p1         = (pending_reg || newly) && (v == plevel_eff);
        elapsed    = now_reg - start_eff;
        fire       = (p1 && (elapsed >= did_pkg::TIME_BITS'(hold_ms_reg))) || bypass;

        level_next   = level_reg;
        known_next   = known_reg;
        pending_next = pending_reg;
        plevel_next  = plevel_reg;
        start_next   = start_reg;
        chg          = 1'b0;

        if (!enable_reg)
        begin
            if (differs)
            begin
                level_next = v;
                known_next = 1'b1;
                chg        = 1'b1;
            end
        end
        else if (active)
        begin
            start_next  = start_eff;
            plevel_next = plevel_eff;
            if (fire)
            begin
                if (differs)
                begin
                    level_next = v;
                    known_next = 1'b1;
                    chg        = 1'b1;
                end
                pending_next = 1'b0;
            end
            else
            begin
                pending_next = p1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= 1'b0;
            known_reg   <= 1'b0;
            pending_reg <= 1'b0;
            plevel_reg  <= 1'b0;
            start_reg   <= '0;
        end
        else if (move)
        begin
            level_reg   <= level_next;
            known_reg   <= known_next;
            pending_reg <= pending_next;
            plevel_reg  <= plevel_next;
            start_reg   <= start_next;
        end
    end

    // result register
    always_comb
    begin
        if (move)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            changed_reg   <= chg;
            out_level_reg <= level_next;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_known_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        known_reg |=> known_reg)
        else $error("level_known dropped after being set");

    a_change_flips: assert property (@(posedge clk) disable iff (!rst_n)
        move && chg && known_reg |=> level_reg != $past(level_reg))
        else $error("change reported without a level flip");

    a_nochg_holds: assert property (@(posedge clk) disable iff (!rst_n)
        move && !chg |=> level_reg == $past(level_reg) && known_reg == $past(known_reg))
        else $error("level changed on an item that reported no change");

    a_pend_arm: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pending_reg) |-> $past(enable_reg) && $past(mode_reg != did_pkg::MODE_NEVER))
        else $error("pending armed with debounce off or mode never");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !move |=> in_vld_reg && $stable(sample_reg) && $stable(now_reg))
        else $error("input stage overwritten while stalled");

endmodule

`default_nettype wire
